FILE: hdl/mcl_pkg.sv
// Shared package for the MRU credential list: field widths, operation
// and status codes, and the controller-to-datapath command type.
// No dependencies.
package mcl_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 64;
    localparam int SEC_W  = 64;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int HPOS_W = 6;
    localparam int CNT_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FIND     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMEMBER = 2'd1;
    localparam logic [OP_W-1:0] OP_FORGET   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNCHANGED = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the beat and register the key matches
        logic apply;    // update the list and load the result registers
    } t_cmd;

    // Index width for a list of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: hdl/mru_credential_list_unit.sv
// Latency: a beat accepted at a clock edge raises its result strobe at the next
// edge; the result is taken at the edge after that, and the receiver cannot stall it.
// A new beat is not accepted while busy; the capture/apply sequencer raises busy
// for the one apply cycle after each accepted beat.
// Reset (synchronous, active low) empties the list and drops the strobe;
// cells past the entry count are never read, so they are not cleared.
module mru_credential_list_unit #(
    parameter int ENTRIES = mcl_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mcl_pkg::OP_W-1:0]     i_operation,
    input  logic [mcl_pkg::KEY_W-1:0]    i_key,
    input  logic [mcl_pkg::SEC_W-1:0]    i_secret,
    input  logic [mcl_pkg::POS_W-1:0]    i_position,
    output logic                         o_valid,
    output logic [mcl_pkg::STAT_W-1:0]   o_status,
    output logic                         o_hit,
    output logic [mcl_pkg::HPOS_W-1:0]   o_hit_position,
    output logic [mcl_pkg::CNT_W-1:0]    o_entry_count_out
);

    mcl_pkg::t_cmd w_cmd;

    // Sequence each beat through capture and apply
    mcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Hold the list and form the result
    mcl_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_operation       (i_operation),
        .i_key             (i_key),
        .i_secret          (i_secret),
        .i_position        (i_position),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_hit             (o_hit),
        .o_hit_position    (o_hit_position),
        .o_entry_count_out (o_entry_count_out)
    );

endmodule

FILE: hdl/mcl_ctrl.sv
// Controller for the MRU credential list: two-state sequencer that
// captures a beat, then applies it in the following cycle.
// Depends on mcl_pkg.
module mcl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output mcl_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // Advance to the execute cycle on each accepted beat
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive the handshake and the datapath commands
    assign busy          = (r_state == S_EXEC);
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.apply   = (r_state == S_EXEC);

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute state held for more than one cycle");

    a_capture_then_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.apply)
        else $error("captured beat not applied in the next cycle");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.apply))
        else $error("capture and apply raised together");

endmodule

FILE: hdl/mcl_dpath.sv
// Datapath for the MRU credential list: a chain of key/secret cells with
// parallel compare, move-to-front and close-gap shifting, result registers.
// Depends on mcl_pkg.
module mcl_dpath #(
    parameter int ENTRIES = mcl_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcl_pkg::t_cmd                i_cmd,
    input  logic [mcl_pkg::OP_W-1:0]     i_operation,
    input  logic [mcl_pkg::KEY_W-1:0]    i_key,
    input  logic [mcl_pkg::SEC_W-1:0]    i_secret,
    input  logic [mcl_pkg::POS_W-1:0]    i_position,
    output logic                         o_valid,
    output logic [mcl_pkg::STAT_W-1:0]   o_status,
    output logic                         o_hit,
    output logic [mcl_pkg::HPOS_W-1:0]   o_hit_position,
    output logic [mcl_pkg::CNT_W-1:0]    o_entry_count_out
);

    localparam int IW = mcl_pkg::idx_w(ENTRIES);
    localparam int CW = mcl_pkg::CNT_W;
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // List cells, position 0 is the most recent
    logic [mcl_pkg::KEY_W-1:0]  r_key [ENTRIES];
    logic [mcl_pkg::SEC_W-1:0]  r_sec [ENTRIES];
    logic [mcl_pkg::KEY_W-1:0]  n_key [ENTRIES];
    logic [mcl_pkg::SEC_W-1:0]  n_sec [ENTRIES];
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;

    // Captured beat
    logic [mcl_pkg::OP_W-1:0]   r_op;
    logic [mcl_pkg::KEY_W-1:0]  r_qkey;
    logic [mcl_pkg::SEC_W-1:0]  r_qsec;
    logic [mcl_pkg::POS_W-1:0]  r_pos;
    logic [ENTRIES-1:0]         r_match;
    logic [ENTRIES-1:0]         n_match;
    logic                       r_sec0_eq;

    logic                       w_found;
    logic [IW-1:0]              w_first;
    logic [CW-1:0]              w_slot;
    logic [mcl_pkg::STAT_W-1:0] w_status;
    logic                       w_hit;
    logic [mcl_pkg::HPOS_W-1:0] w_hpos;

    logic                       r_valid;
    logic [mcl_pkg::STAT_W-1:0] r_status;
    logic                       r_hit;
    logic [mcl_pkg::HPOS_W-1:0] r_hpos;
    logic [CW-1:0]              r_cnt_out;

    // Compare the incoming key against every live cell
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i] = (CW'(i) < r_count) && (r_key[i] == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_qkey    <= i_key;
            r_qsec    <= i_secret;
            r_pos     <= i_position;
            r_match   <= n_match;
            r_sec0_eq <= (r_sec[0] == i_secret);
        end
    end

    // Pick the most recent match and work out the new list
    always_comb begin
        w_found = |r_match;
        w_first = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) w_first = IW'(i);
        end

        n_key    = r_key;
        n_sec    = r_sec;
        n_count  = r_count;
        w_slot   = '0;
        w_status = mcl_pkg::ST_IGNORED;
        w_hit    = 1'b0;
        w_hpos   = '0;

        case (r_op)
            mcl_pkg::OP_FIND: begin
                w_status = mcl_pkg::ST_DONE;
                w_hit    = w_found;
                w_hpos   = mcl_pkg::HPOS_W'(w_first);
            end
            mcl_pkg::OP_REMEMBER: begin
                if (r_qkey != '0) begin
                    if (w_found && (w_first == '0) && r_sec0_eq) begin
                        w_status = mcl_pkg::ST_UNCHANGED;
                    end else begin
                        // hit moves up from its slot; miss takes a new or the oldest slot
                        if (w_found) begin
                            w_slot = CW'(w_first);
                        end else if (r_count >= FULL) begin
                            w_slot = FULL - CW'(1);
                        end else begin
                            w_slot  = r_count;
                            n_count = r_count + CW'(1);
                        end
                        for (int i = 1; i < ENTRIES; i++) begin
                            if (CW'(i) <= w_slot) begin
                                n_key[i] = r_key[i-1];
                                n_sec[i] = r_sec[i-1];
                            end
                        end
                        n_key[0] = r_qkey;
                        n_sec[0] = r_qsec;
                        w_status = mcl_pkg::ST_DONE;
                    end
                end
            end
            mcl_pkg::OP_FORGET: begin
                if ({1'b0, r_count} > r_pos) begin
                    // close the gap, then clear the freed tail cell
                    for (int i = 0; i < ENTRIES - 1; i++) begin
                        if (({1'b0, CW'(i)} >= r_pos) && (CW'(i + 1) < r_count)) begin
                            n_key[i] = r_key[i+1];
                            n_sec[i] = r_sec[i+1];
                        end
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (CW'(i) == (r_count - CW'(1))) begin
                            n_key[i] = '0;
                            n_sec[i] = '0;
                        end
                    end
                    n_count  = r_count - CW'(1);
                    w_status = mcl_pkg::ST_DONE;
                end
            end
            default: begin
                w_status = mcl_pkg::ST_IGNORED;
            end
        endcase
    end

    // Commit the list update
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_key <= n_key;
            r_sec <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    // Result registers: strobe for one cycle after each apply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status  <= w_status;
            r_hit     <= w_hit;
            r_hpos    <= w_hpos;
            r_cnt_out <= n_count;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_hit             = r_hit;
    assign o_hit_position    = r_hpos;
    assign o_entry_count_out = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count beyond list depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.apply |=> $stable(r_count))
        else $error("entry count changed outside an apply cycle");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_status == mcl_pkg::ST_DONE))
        else $error("hit reported with a status other than done");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> ({1'b0, o_hit_position} < o_entry_count_out))
        else $error("hit position outside the live entries");

endmodule

FILE: verif/tb.sv
// Self-checking bench for mru_credential_list_unit: a shadow MRU list class predicts each
// result beat and checks it. Depends on mcl_pkg and on the unit's
// RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              OP_W         = mcl_pkg::OP_W;
    localparam int              KEY_W        = mcl_pkg::KEY_W;
    localparam int              SEC_W        = mcl_pkg::SEC_W;
    localparam int              POS_W        = mcl_pkg::POS_W;
    localparam int              STAT_W       = mcl_pkg::STAT_W;
    localparam int              HPOS_W       = mcl_pkg::HPOS_W;
    localparam int              CNT_W        = mcl_pkg::CNT_W;
    localparam int              LIST_DEPTH   = mcl_pkg::ENTRIES_DEF;
    localparam int              RANDOM_BEATS = 400;
    localparam int              QUIET_TAIL   = 60;
    localparam int              KEY_POOL     = 12;
    localparam logic [OP_W-1:0] OP_RESERVED  = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [HPOS_W-1:0] hit_position;
        logic [CNT_W-1:0]  entry_count_out;
    } t_list_result;

    // Shadow copy of the list, with the result beats still owed by the unit
    class mru_list_shadow;
        logic [KEY_W-1:0] keys[LIST_DEPTH];
        logic [SEC_W-1:0] secrets[LIST_DEPTH];
        int               fill;
        t_list_result     owed_results[$];
        int               mismatches;

        function new();
            foreach (keys[i]) begin
                keys[i]    = '0;
                secrets[i] = '0;
            end
            fill       = 0;
            mismatches = 0;
        endfunction

        // Return the newest valid position holding the key, or -1
        function int locate(logic [KEY_W-1:0] key);
            for (int i = 0; i < fill; i++) begin
                if (keys[i] == key) return i;
            end
            return -1;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted beat to the shadow list and queue its result
        function void note_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [SEC_W-1:0] secret, logic [POS_W-1:0] pos);
            t_list_result res;
            int           at;
            int           slot;
            res.status       = mcl_pkg::ST_IGNORED;
            res.hit          = 1'b0;
            res.hit_position = '0;
            case (op)
                mcl_pkg::OP_FIND: begin
                    at         = locate(key);
                    res.status = mcl_pkg::ST_DONE;
                    if (at >= 0) begin
                        res.hit          = 1'b1;
                        res.hit_position = HPOS_W'(at);
                    end
                end
                mcl_pkg::OP_REMEMBER: begin
                    if (key != '0) begin
                        at = locate(key);
                        if (at == 0 && secrets[0] == secret) begin
                            res.status = mcl_pkg::ST_UNCHANGED;
                        end else begin
                            // pick the slot to overwrite: the key itself, a free one, or the oldest
                            if (at >= 0) begin
                                slot = at;
                            end else if (fill >= LIST_DEPTH) begin
                                slot = LIST_DEPTH - 1;
                            end else begin
                                slot = fill;
                                fill++;
                            end
                            for (int i = slot; i > 0; i--) begin
                                keys[i]    = keys[i-1];
                                secrets[i] = secrets[i-1];
                            end
                            keys[0]    = key;
                            secrets[0] = secret;
                            res.status = mcl_pkg::ST_DONE;
                        end
                    end
                end
                mcl_pkg::OP_FORGET: begin
                    if (int'(pos) < fill) begin
                        // close the gap and clear the freed tail slot
                        for (int i = int'(pos); i + 1 < fill; i++) begin
                            keys[i]    = keys[i+1];
                            secrets[i] = secrets[i+1];
                        end
                        fill--;
                        keys[fill]    = '0;
                        secrets[fill] = '0;
                        res.status    = mcl_pkg::ST_DONE;
                    end
                end
                default: ;
            endcase
            res.entry_count_out = CNT_W'(fill);
            owed_results.push_back(res);
        endfunction

        // Compare one result beat with the oldest owed result
        function void check_beat(t_list_result got);
            t_list_result want;
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: status %0d hit %0d pos %0d count %0d",
                       got.status, got.hit, got.hit_position, got.entry_count_out);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                mismatches++;
            end
            if (got.hit_position !== want.hit_position) begin
                $error("hit_position: expected %0d, got %0d",
                       want.hit_position, got.hit_position);
                mismatches++;
            end
            if (got.entry_count_out !== want.entry_count_out) begin
                $error("entry_count_out: expected %0d, got %0d",
                       want.entry_count_out, got.entry_count_out);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [KEY_W-1:0]   i_key;
    logic [SEC_W-1:0]   i_secret;
    logic [POS_W-1:0]   i_position;
    logic               o_valid;
    logic [STAT_W-1:0]  o_status;
    logic               o_hit;
    logic [HPOS_W-1:0]  o_hit_position;
    logic [CNT_W-1:0]   o_entry_count_out;

    mru_list_shadow     tracker = new();
    logic [KEY_W-1:0]   key_pool[KEY_POOL];
    logic [SEC_W-1:0]   secret_pool[4];

    mru_credential_list_unit #(.ENTRIES(LIST_DEPTH)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_key             (i_key),
        .i_secret          (i_secret),
        .i_position        (i_position),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_hit             (o_hit),
        .o_hit_position    (o_hit_position),
        .o_entry_count_out (o_entry_count_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Check every result strobe against the oldest owed result
    always @(posedge i_clk) begin
        t_list_result got;
        if (i_rst_n && o_valid !== 1'b0) begin
            got.status          = o_status;
            got.hit             = o_hit;
            got.hit_position    = o_hit_position;
            got.entry_count_out = o_entry_count_out;
            tracker.check_beat(got);
        end
    end

    // Present one beat from a falling edge and hold it until accepted;
    // return at the next falling edge with start still high
    task automatic send_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [SEC_W-1:0] secret, logic [POS_W-1:0] pos);
        i_operation = op;
        i_key       = key;
        i_secret    = secret;
        i_position  = pos;
        start       = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_beat(op, key, secret, pos);
        @(negedge i_clk);
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Walk the corner cases: empty list, ignored codes, fill, eviction, forget ends
    task automatic run_directed();
        logic [KEY_W-1:0] ones;
        ones = '1;
        send_beat(mcl_pkg::OP_FIND, '0, '0, '0);
        send_beat(mcl_pkg::OP_REMEMBER, '0, '1, '0);
        send_beat(mcl_pkg::OP_FORGET, ones, '0, 8'd0);
        send_beat(OP_RESERVED, ones, '1, 8'hff);
        send_beat(mcl_pkg::OP_REMEMBER, ones, '1, 8'hff);
        send_beat(mcl_pkg::OP_REMEMBER, ones, '1, '0);
        send_beat(mcl_pkg::OP_REMEMBER, ones, '0, '0);
        for (int i = 1; i <= LIST_DEPTH; i++) begin
            send_beat(mcl_pkg::OP_REMEMBER, KEY_W'(i), SEC_W'(i) << 32, '0);
        end
        send_beat(mcl_pkg::OP_FIND, KEY_W'(1), '0, '0);
        send_beat(mcl_pkg::OP_FIND, ones, '0, '0);
        send_beat(mcl_pkg::OP_REMEMBER, KEY_W'(4), '1, '0);
        send_beat(mcl_pkg::OP_FORGET, '0, '0, 8'hff);
        send_beat(mcl_pkg::OP_FORGET, '0, '0, POS_W'(LIST_DEPTH - 1));
        send_beat(mcl_pkg::OP_FORGET, '0, '0, 8'd0);
        send_beat(mcl_pkg::OP_FORGET, '0, '0, POS_W'(tracker.fill));
        send_beat(mcl_pkg::OP_FIND, '0, '0, '0);
    endtask

    // Mostly pooled keys so finds hit and the list churns between empty and full
    task automatic run_random();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [SEC_W-1:0] secret;
        logic [POS_W-1:0] pos;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '1;
        foreach (secret_pool[i]) secret_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // drain once mid-run so the unit goes fully idle
            if (n == RANDOM_BEATS / 2) begin
                start = 1'b0;
                while (tracker.pending() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = mcl_pkg::OP_FIND;
            else if (pick < 75) op = mcl_pkg::OP_REMEMBER;
            else if (pick < 95) op = mcl_pkg::OP_FORGET;
            else                op = OP_RESERVED;
            pick = $urandom_range(0, 99);
            if (pick < 80)      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else if (pick < 92) key = {$urandom, $urandom};
            else                key = '0;
            secret = $urandom_range(0, 1) ? secret_pool[$urandom_range(0, 3)]
                                          : {$urandom, $urandom};
            pos = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, tracker.fill))
                                              : POS_W'($urandom_range(0, 255));
            // re-remember the front entry, sometimes with its own secret
            if (op == mcl_pkg::OP_REMEMBER && tracker.fill > 0 && $urandom_range(0, 5) == 0) begin
                key = tracker.keys[0];
                if ($urandom_range(0, 1)) secret = tracker.secrets[0];
            end
            send_beat(op, key, secret, pos);
            if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 8));
            end
        end
        start = 1'b0;
    endtask

    initial begin
        start       = 1'b0;
        i_operation = mcl_pkg::OP_FIND;
        i_key       = '0;
        i_secret    = '0;
        i_position  = '0;
        i_rst_n     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        run_random();
        // wait for the last results, then let the pipeline settle
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("mru_credential_list_unit regression: pass");
        end else begin
            $display("mru_credential_list_unit regression: fail");
        end
        $finish;
    end

    // Abandon a hung run
    initial begin
        #2ms;
        $display("mru_credential_list_unit regression: fail");
        $finish;
    end

endmodule

FILE: mru_credential_list_unit.f
hdl/mcl_pkg.sv
hdl/mcl_ctrl.sv
hdl/mcl_dpath.sv
hdl/mru_credential_list_unit.sv
verif/tb.sv
